>>> rtl/core/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants for the template match counter
// Field widths, register codes, reset values and the sizes of the
// chi-square multiply sequence.
// ----------------------------------------------------------------------------
package ntc_pkg;

	// defaults for the top-level parameters
	localparam int MAX_TEMPLATE_BITS_DEF = 16;
	localparam int BLOCK_LENGTH_BITS_DEF = 24;
	localparam int MAX_BLOCKS_DEF        = 256;

	// fixed field widths
	localparam int INDEX_W      = 8;
	localparam int COUNT_W      = 24;
	localparam int CHI_W        = 48;
	localparam int FRAC_W       = 16;
	localparam int MEAN_W       = 32;
	localparam int NUM_BLOCKS_W = 9;
	localparam int TLEN_W       = 5;
	localparam int TPAT_W       = 16;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_INDEX_W  = 3;

	// register reset values
	localparam int RESET_NUM_BLOCKS       = 8;
	localparam int RESET_BLOCK_LENGTH     = 1024;
	localparam int RESET_TEMPLATE_LENGTH  = 9;
	localparam int RESET_TEMPLATE_PATTERN = 1;
	localparam logic [MEAN_W-1:0] RESET_EXPECTED_MEAN    = 32'd130048;
	localparam logic [MEAN_W-1:0] RESET_INVERSE_VARIANCE = 32'd65536;

	// block-end queue and chi-square multiply sequence
	localparam int QUEUE_DEPTH = 4;
	localparam int DIGIT_W     = 8;
	localparam int DIFF_W      = COUNT_W + FRAC_W;        // |count*2^16 - mean|
	localparam int SQ_W        = 2 * DIFF_W - FRAC_W;     // d*d / 2^16
	localparam int PROD_W      = SQ_W + MEAN_W;           // sq * inverse variance
	localparam int MUL1_STEPS  = (DIFF_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MUL2_STEPS  = (MEAN_W + DIGIT_W - 1) / DIGIT_W;
	localparam int STEP_W      = $clog2(MUL1_STEPS + 1);

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NUM_BLOCKS       = 3'd0,
		REG_BLOCK_LENGTH     = 3'd1,
		REG_TEMPLATE_LENGTH  = 3'd2,
		REG_TEMPLATE_PATTERN = 3'd3,
		REG_EXPECTED_MEAN    = 3'd4,
		REG_INVERSE_VARIANCE = 3'd5
	} cfg_reg_t;

	// width of the block length register and position counter:
	// wide enough for the configured width and for the reset value
	function automatic int len_width(input int blb);
		int w;
		w = $clog2(RESET_BLOCK_LENGTH + 1);
		return (blb > w) ? blb : w;
	endfunction

	// input item
	typedef struct packed {
		logic data_bit;
		logic restart;
	} in_t;

	// result item
	typedef struct packed {
		logic [INDEX_W-1:0] block_index;
		logic [COUNT_W-1:0] match_count;
		logic [CHI_W-1:0]   chi_square;
		logic               final_block;
		logic               config_error;
	} out_t;

	// block-end event from the matcher to the chi-square unit
	typedef struct packed {
		logic [INDEX_W-1:0] block_index;
		logic [COUNT_W-1:0] match_count;
		logic               final_block;
		logic               config_error;
		logic               first;       // first block since restart: clear the sum
	} ev_t;

endpackage

>>> rtl/core/non_overlapping_template_counter_top.sv
// ----------------------------------------------------------------------------
// non_overlapping_template_counter_top: template match counter, top level
// Configuration registers, matcher, event queue and chi-square unit.
// ----------------------------------------------------------------------------
// The block takes one sequence bit per clock while in_stall is low and
// counts non-overlapping template matches per block. Each block end
// queues one event (four entries deep) for the chi-square unit, which
// per block loads the difference, runs five digit steps for the square and
// four digit steps for the inverse-variance product, adds, and then hands
// over the result. Blocks at least as long as that sequence run at one bit
// per clock while the output is not stalled; otherwise the input stalls once
// the queue is full. chi_square saturates at 2^48-1 and is cleared by a
// restart. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module non_overlapping_template_counter_top #(
	parameter int MAX_TEMPLATE_BITS = ntc_pkg::MAX_TEMPLATE_BITS_DEF,
	parameter int BLOCK_LENGTH_BITS = ntc_pkg::BLOCK_LENGTH_BITS_DEF,
	parameter int MAX_BLOCKS        = ntc_pkg::MAX_BLOCKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ntc_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ntc_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [ntc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ntc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ntc_pkg::*;

	localparam int LEN_W = len_width(BLOCK_LENGTH_BITS);

	logic [NUM_BLOCKS_W-1:0] block_count_q;
	logic [LEN_W-1:0]        block_length_q;
	logic [TLEN_W-1:0]       template_length_q;
	logic [TPAT_W-1:0]       template_pattern_q;
	logic [MEAN_W-1:0]       expected_mean_q;
	logic [MEAN_W-1:0]       inverse_variance_q;

	logic take, ev_push, q_pop, q_full, q_empty;
	ev_t  ev_data, q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q      <= NUM_BLOCKS_W'(RESET_NUM_BLOCKS);
			block_length_q     <= LEN_W'(RESET_BLOCK_LENGTH);
			template_length_q  <= TLEN_W'(RESET_TEMPLATE_LENGTH);
			template_pattern_q <= TPAT_W'(RESET_TEMPLATE_PATTERN);
			expected_mean_q    <= RESET_EXPECTED_MEAN;
			inverse_variance_q <= RESET_INVERSE_VARIANCE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NUM_BLOCKS:       block_count_q      <= cfg_data[NUM_BLOCKS_W-1:0];
				REG_BLOCK_LENGTH:     block_length_q     <= LEN_W'(cfg_data[BLOCK_LENGTH_BITS-1:0]);
				REG_TEMPLATE_LENGTH:  template_length_q  <= cfg_data[TLEN_W-1:0];
				REG_TEMPLATE_PATTERN: template_pattern_q <= cfg_data[TPAT_W-1:0];
				REG_EXPECTED_MEAN:    expected_mean_q    <= cfg_data[MEAN_W-1:0];
				REG_INVERSE_VARIANCE: inverse_variance_q <= cfg_data[MEAN_W-1:0];
				default: begin
					block_count_q <= block_count_q;
				end
			endcase
		end
	end

	// hold input while the event queue is full
	assign in_stall = q_full;
	assign take     = in_valid & ~in_stall;

	ntc_front #(
		.MAX_TEMPLATE_BITS (MAX_TEMPLATE_BITS),
		.BLOCK_LENGTH_BITS (BLOCK_LENGTH_BITS),
		.MAX_BLOCKS        (MAX_BLOCKS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.in_data          (in_data),
		.block_count      (block_count_q),
		.block_length     (block_length_q),
		.template_length  (template_length_q),
		.template_pattern (template_pattern_q),
		.ev_push          (ev_push),
		.ev_data          (ev_data)
	);

	ntc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.push_data (ev_data),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	ntc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_data           (q_data),
		.q_pop            (q_pop),
		.expected_mean    (expected_mean_q),
		.inverse_variance (inverse_variance_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_data         (out_data)
	);

endmodule

>>> rtl/core/ntc_front.sv
// ----------------------------------------------------------------------------
// ntc_front: bit matcher
// Takes one sequence bit per transfer, tracks the template window, the skip
// count after a hit and the block position, and pushes one event per block.
// ----------------------------------------------------------------------------
module ntc_front #(
	parameter int MAX_TEMPLATE_BITS = ntc_pkg::MAX_TEMPLATE_BITS_DEF,
	parameter int BLOCK_LENGTH_BITS = ntc_pkg::BLOCK_LENGTH_BITS_DEF,
	parameter int MAX_BLOCKS        = ntc_pkg::MAX_BLOCKS_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                take,
	input  ntc_pkg::in_t                                        in_data,
	input  logic [ntc_pkg::NUM_BLOCKS_W-1:0]                    block_count,
	input  logic [ntc_pkg::len_width(BLOCK_LENGTH_BITS)-1:0]    block_length,
	input  logic [ntc_pkg::TLEN_W-1:0]                          template_length,
	input  logic [ntc_pkg::TPAT_W-1:0]                          template_pattern,
	output logic                                                ev_push,
	output ntc_pkg::ev_t                                        ev_data
);
	import ntc_pkg::*;

	localparam int LEN_W  = len_width(BLOCK_LENGTH_BITS);
	localparam int M_W    = $clog2(MAX_TEMPLATE_BITS + 1);
	localparam int SKIP_W = $clog2(MAX_TEMPLATE_BITS);
	localparam int CB_W   = $clog2(MAX_BLOCKS + 1);

	logic [MAX_TEMPLATE_BITS-1:0] win_q;
	logic [LEN_W-1:0]             pos_q;
	logic [SKIP_W-1:0]            skip_q;
	logic [COUNT_W-1:0]           hit_q;
	logic [CB_W-1:0]              cb_q;
	logic                         fresh_q;

	logic [M_W-1:0]               m;
	logic [LEN_W-1:0]             len;
	logic [CB_W-1:0]              nb;
	logic [MAX_TEMPLATE_BITS-1:0] win_c, win_n, pat_ext;
	logic [LEN_W-1:0]             pos_c;
	logic [SKIP_W-1:0]            skip_c, skip_n;
	logic [COUNT_W-1:0]           hit_c, hit_n;
	logic [CB_W-1:0]              cb_c;
	logic                         fresh_c;
	logic                         active, match, can_match, last;
	logic [LEN_W:0]               pos1;

	// effective template length, block length and block count
	always_comb begin
		if (template_length == '0) begin
			m = M_W'(1);
		end else if (32'(template_length) > 32'(MAX_TEMPLATE_BITS)) begin
			m = M_W'(MAX_TEMPLATE_BITS);
		end else begin
			m = M_W'(template_length);
		end
		len = (block_length == '0) ? LEN_W'(1) : block_length;
		nb  = (32'(block_count) > 32'(MAX_BLOCKS)) ? CB_W'(MAX_BLOCKS) : CB_W'(block_count);
	end

	// state as seen by this bit: restart clears it first
	assign win_c   = in_data.restart ? '0 : win_q;
	assign pos_c   = in_data.restart ? '0 : pos_q;
	assign skip_c  = in_data.restart ? '0 : skip_q;
	assign hit_c   = in_data.restart ? '0 : hit_q;
	assign cb_c    = in_data.restart ? '0 : cb_q;
	assign fresh_c = in_data.restart | fresh_q;

	assign active  = cb_c < nb;
	assign win_n   = {win_c[MAX_TEMPLATE_BITS-2:0], in_data.data_bit};
	assign pat_ext = MAX_TEMPLATE_BITS'(template_pattern);

	// window bit j (newest is 0) must equal template bit m-1-j
	always_comb begin
		logic [SKIP_W-1:0] idx;
		match = 1'b1;
		idx   = '0;
		for (int j = 0; j < MAX_TEMPLATE_BITS; j++) begin
			idx = SKIP_W'(int'(m) - 1 - j);
			if (j < int'(m) && win_n[j] != pat_ext[idx]) begin
				match = 1'b0;
			end
		end
	end

	assign pos1      = {1'b0, pos_c} + (LEN_W + 1)'(1);
	assign can_match = pos1 >= (LEN_W + 1)'(m);
	assign last      = pos1 >= {1'b0, len};

	// skip after a hit, else count a hit
	always_comb begin
		skip_n = skip_c;
		hit_n  = hit_c;
		if (skip_c != '0) begin
			skip_n = skip_c - SKIP_W'(1);
		end else if (can_match && match) begin
			hit_n  = hit_c + COUNT_W'(1);
			skip_n = SKIP_W'(m - M_W'(1));
		end
	end

	// block-end event
	assign ev_push              = take & active & last;
	assign ev_data.block_index  = INDEX_W'(cb_c);
	assign ev_data.match_count  = hit_n;
	assign ev_data.final_block  = ({1'b0, cb_c} + (CB_W + 1)'(1)) == {1'b0, nb};
	assign ev_data.config_error = len < LEN_W'(m);
	assign ev_data.first        = fresh_c;

	// advance the matcher state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			pos_q   <= '0;
			skip_q  <= '0;
			hit_q   <= '0;
			cb_q    <= '0;
			fresh_q <= 1'b1;
		end else if (take) begin
			if (!active) begin
				win_q   <= win_c;
				pos_q   <= pos_c;
				skip_q  <= skip_c;
				hit_q   <= hit_c;
				cb_q    <= cb_c;
				fresh_q <= fresh_c;
			end else if (last) begin
				win_q   <= win_n;
				pos_q   <= '0;
				skip_q  <= '0;
				hit_q   <= '0;
				cb_q    <= cb_c + CB_W'(1);
				fresh_q <= 1'b0;
			end else begin
				win_q   <= win_n;
				pos_q   <= pos1[LEN_W-1:0];
				skip_q  <= skip_n;
				hit_q   <= hit_n;
				cb_q    <= cb_c;
				fresh_q <= fresh_c;
			end
		end
	end

endmodule

>>> rtl/core/ntc_queue.sv
// ----------------------------------------------------------------------------
// ntc_queue: block-end event queue
// Short register queue that lets the matcher run ahead of the chi-square unit.
// ----------------------------------------------------------------------------
module ntc_queue #(
	parameter int DEPTH = ntc_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  ntc_pkg::ev_t push_data,
	input  logic         pop,
	output ntc_pkg::ev_t pop_data,
	output logic         full,
	output logic         empty
);
	import ntc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ev_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count above depth");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> $stable(wr_ptr_q))
		else $error("queue write pointer moved while full");

endmodule

>>> rtl/core/ntc_back.sv
// ----------------------------------------------------------------------------
// ntc_back: chi-square unit
// Pops one block-end event, forms (count - mean)^2 * inverse variance with a
// shared 8-bit-digit multiplier, adds it to the saturating sum, and holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
module ntc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  ntc_pkg::ev_t                  q_data,
	output logic                          q_pop,
	input  logic [ntc_pkg::MEAN_W-1:0]    expected_mean,
	input  logic [ntc_pkg::MEAN_W-1:0]    inverse_variance,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ntc_pkg::out_t                 out_data
);
	import ntc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL1 = 5'b00010,
		S_MUL2 = 5'b00100,
		S_ACC  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	ev_t                 ev_q;
	logic [PROD_W-1:0]   a_q;
	logic [DIFF_W-1:0]   b_q;
	logic [PROD_W-1:0]   acc_q;
	logic [CHI_W-1:0]    term_q;
	logic [CHI_W-1:0]    chi_q;
	logic                out_valid_q;
	out_t                out_q;

	logic [DIFF_W-1:0]   scaled, mean_ext, diff;
	logic [DIGIT_W-1:0]  digit;
	logic [PROD_W-1:0]   pp, acc_sum;
	logic [CHI_W-1:0]    term;
	logic [CHI_W-1:0]    base;
	logic [CHI_W:0]      chi_sum;
	logic                mul1_done, mul2_done;

	// absolute difference of the scaled count and the mean
	assign scaled   = {q_data.match_count, FRAC_W'(0)};
	assign mean_ext = DIFF_W'(expected_mean);
	assign diff     = (scaled >= mean_ext) ? scaled - mean_ext : mean_ext - scaled;

	// one digit of the multiplier per cycle
	assign digit   = b_q[DIGIT_W-1:0];
	assign pp      = a_q * PROD_W'(digit);
	assign acc_sum = acc_q + pp;

	assign mul1_done = step_q == STEP_W'(MUL1_STEPS - 1);
	assign mul2_done = step_q == STEP_W'(MUL2_STEPS - 1);

	// clip the product / 2^16 to the sum width
	assign term = (|acc_sum[PROD_W-1:CHI_W+FRAC_W]) ? '1 : acc_sum[FRAC_W +: CHI_W];

	// saturating sum, cleared at the first block of a sequence
	assign base    = ev_q.first ? '0 : chi_q;
	assign chi_sum = {1'b0, base} + {1'b0, term_q};

	assign q_pop     = (state_q == S_IDLE) & ~q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			chi_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (!q_empty) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					if (mul1_done) begin
						step_q  <= '0;
						state_q <= S_MUL2;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_MUL2: begin
					if (mul2_done) begin
						step_q  <= '0;
						state_q <= S_ACC;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_ACC: begin
					chi_q       <= chi_sum[CHI_W] ? '1 : chi_sum[CHI_W-1:0];
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// multiply datapath and output register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ev_q  <= q_data;
				a_q   <= PROD_W'(diff);
				b_q   <= diff;
				acc_q <= '0;
			end
			S_MUL1: begin
				if (mul1_done) begin
					a_q   <= PROD_W'(acc_sum[FRAC_W +: SQ_W]);
					b_q   <= DIFF_W'(inverse_variance);
					acc_q <= '0;
				end else begin
					a_q   <= a_q << DIGIT_W;
					b_q   <= b_q >> DIGIT_W;
					acc_q <= acc_sum;
				end
			end
			S_MUL2: begin
				a_q   <= a_q << DIGIT_W;
				b_q   <= b_q >> DIGIT_W;
				acc_q <= acc_sum;
				if (mul2_done) begin
					term_q <= term;
				end
			end
			S_ACC: begin
				out_q.block_index  <= ev_q.block_index;
				out_q.match_count  <= ev_q.match_count;
				out_q.chi_square   <= chi_sum[CHI_W] ? '1 : chi_sum[CHI_W-1:0];
				out_q.final_block  <= ev_q.final_block;
				out_q.config_error <= ev_q.config_error;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == S_OUT)
		else $error("result shown outside the output state");

	a_rose_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_ACC))
		else $error("result raised without an accumulate step");

	a_mul_chain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL1 && mul1_done |=> state_q == S_MUL2 && step_q == '0)
		else $error("second multiply did not follow the first");

endmodule
